// File: rtl/core/ksdf_pkg.sv
package ksdf_pkg;

    // Width of a key position or a held prefix length (keys up to 16 bytes).
    localparam int KEY_CNT_W = 4;

    // Width of the frame length field on a marker.
    localparam int FRAME_LEN_W = 24;

    // Reset value of the stuff byte register ('X').
    localparam logic [7:0] STUFF_RESET = 8'd88;

    // Number of commands the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [KEY_CNT_W-1:0] key_cnt_t;

    // One command from the classifier to the emitter.
    typedef struct packed {
        logic       is_marker;   // Emit a frame end marker.
        logic       trunc;       // Marker closes a truncated frame.
        key_cnt_t   flush_len;   // Held key bytes to emit first.
        logic       has_byte;    // Emit data_byte after the held bytes.
        logic [7:0] data_byte;
    } cmd_t;

    // Twelve-byte terminator key; positions past the twelfth read as zero.
    function automatic logic [7:0] key_byte(input key_cnt_t idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h66;
            4'd1:    b = 8'h74;
            4'd2:    b = 8'h5F;
            4'd3:    b = 8'h53;
            4'd4:    b = 8'h74;
            4'd5:    b = 8'h55;
            4'd6:    b = 8'h66;
            4'd7:    b = 8'h46;
            4'd8:    b = 8'h5F;
            4'd9:    b = 8'h6B;
            4'd10:   b = 8'h65;
            4'd11:   b = 8'h79;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/ksdf_if.sv
// Received byte channel.
interface ksdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// Recovered result channel.
interface ksdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        is_marker;
    logic        truncated;
    logic [23:0] frame_length;
    logic        last;

    modport source (output valid, output data_byte, output is_marker, output truncated,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input data_byte, input is_marker, input truncated,
                    input frame_length, input last, output ready);
endinterface

// File: rtl/core/ksdf_front.sv
module ksdf_front #(
    parameter int KEY_LEN = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    ksdf_in_if.sink           in_ch,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              q_full,
    output logic              q_push,
    output ksdf_pkg::cmd_t    q_cmd
);
    import ksdf_pkg::*;

    localparam key_cnt_t LAST_POS = KEY_CNT_W'(KEY_LEN - 1);

    key_cnt_t   match_reg, match_next;
    logic [7:0] stuff_reg;
    logic       accept;
    logic       key_hit;
    logic       at_last;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign key_hit     = (key_byte(match_reg) == in_ch.in_byte);
    assign at_last     = (match_reg == LAST_POS);

    // Classify the accepted byte and decide what the emitter must do.
    always_comb
    begin
        match_next       = match_reg;
        q_push           = 1'b0;
        q_cmd.is_marker  = 1'b0;
        q_cmd.trunc      = 1'b0;
        q_cmd.flush_len  = match_reg;
        q_cmd.has_byte   = 1'b0;
        q_cmd.data_byte  = in_ch.in_byte;
        if (accept)
        begin
            priority if (in_ch.stream_end)
            begin
                // End of stream drops the held prefix and closes the frame.
                q_push          = 1'b1;
                q_cmd.is_marker = 1'b1;
                q_cmd.trunc     = 1'b1;
                match_next      = '0;
            end
            else if (key_hit)
            begin
                if (at_last)
                begin
                    q_push          = 1'b1;
                    q_cmd.is_marker = 1'b1;
                    match_next      = '0;
                end
                else
                begin
                    match_next = match_reg + 1'b1;
                end
            end
            else if (at_last && in_ch.in_byte == stuff_reg)
            begin
                // Stuffed key: release the prefix, drop the stuff byte.
                q_push     = 1'b1;
                match_next = '0;
            end
            else
            begin
                q_push         = 1'b1;
                q_cmd.has_byte = 1'b1;
                match_next     = '0;
            end
        end
    end

    // Match position and stuff byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            stuff_reg <= STUFF_RESET;
        end
        else
        begin
            match_reg <= match_next;
            if (cfg_wr_en)
            begin
                stuff_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: rtl/core/ksdf_cmd_queue.sv
module ksdf_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ksdf_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output ksdf_pkg::cmd_t    head
);
    import ksdf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/ksdf_back.sv
module ksdf_back #(
    parameter int LENGTH_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ksdf_pkg::cmd_t    q_head,
    output logic              q_pop,
    ksdf_out_if.source        out_ch
);
    import ksdf_pkg::*;

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    key_cnt_t               idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             data_reg, data_next;
    logic                   marker_reg, marker_next;
    logic                   trunc_reg, trunc_next;
    logic [FRAME_LEN_W-1:0] len_reg, len_next;
    logic                   last_reg, last_next;
    logic [FRAME_LEN_W-1:0] count_field;
    logic                   can_load;
    logic                   step;
    logic                   has_key;
    logic                   is_final;

    // Fit the saturating counter into the frame length field.
    if (LENGTH_BITS >= FRAME_LEN_W)
    begin : g_len_trunc
        assign count_field = count_reg[FRAME_LEN_W-1:0];
    end
    else
    begin : g_len_ext
        assign count_field = {{(FRAME_LEN_W - LENGTH_BITS){1'b0}}, count_reg};
    end

    assign can_load = !out_valid_reg || out_ch.ready;
    assign step     = can_load && !q_empty;
    assign has_key  = (idx_reg < q_head.flush_len);
    assign q_pop    = step && is_final;

    // The head command's last result is the marker, its byte, or its last held key byte.
    always_comb
    begin
        if (q_head.is_marker)
        begin
            is_final = 1'b1;
        end
        else if (q_head.has_byte)
        begin
            is_final = !has_key;
        end
        else
        begin
            is_final = (KEY_CNT_W'(idx_reg + 1'b1) == q_head.flush_len);
        end
    end

    // Build one result per step and keep the payload count.
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        marker_next    = marker_reg;
        trunc_next     = trunc_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            last_next      = is_final;
            idx_next       = is_final ? '0 : idx_reg + 1'b1;
            if (q_head.is_marker)
            begin
                data_next   = 8'd0;
                marker_next = 1'b1;
                trunc_next  = q_head.trunc;
                len_next    = count_field;
                count_next  = '0;
            end
            else
            begin
                data_next   = has_key ? key_byte(idx_reg) : q_head.data_byte;
                marker_next = 1'b0;
                trunc_next  = 1'b0;
                len_next    = '0;
                if (!(&count_reg))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        marker_reg <= marker_next;
        trunc_reg  <= trunc_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.data_byte    = data_reg;
    assign out_ch.is_marker    = marker_reg;
    assign out_ch.truncated    = trunc_reg;
    assign out_ch.frame_length = len_reg;
    assign out_ch.last         = last_reg;

endmodule

// File: rtl/core/key_stuffed_stream_deframer_unit.sv
// Deframer for a byte stream whose files end in a stuffed terminator key.
// in_ch carries one received byte per item, or a stream end flag. out_ch
// carries recovered data bytes and frame end markers; last marks the final
// result caused by one input item. cfg_wr_en/cfg_wr_data write the stuff byte
// and should only be used while the block is idle.
// A classifier accepts one item per cycle while the queue is not full and
// tracks the key match position. Items that need output become commands in
// a four-entry queue. An emitter drains it into an output register, one
// result per cycle while out_ch is free. With the queue empty and out_ch
// free, an accepted item is registered in the queue, then its first result
// in the output register. Throughput: one input item per cycle while the
// emitter keeps up. A command releasing n held key bytes gives n results, or
// n+1 with its data byte, so in_ch.ready drops as the queue fills behind it.
// When the receiver stalls, the output register holds its result, the
// emitter waits, and the queue fills until in_ch.ready falls.
// Reset clears the match position, the payload count and the queue, and
// restores the stuff byte to 'X'.
module key_stuffed_stream_deframer_unit #(
    parameter int KEY_LEN     = 12,
    parameter int LENGTH_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    ksdf_in_if.sink    in_ch,
    ksdf_out_if.source out_ch,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import ksdf_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    ksdf_front #(
        .KEY_LEN (KEY_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    ksdf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    ksdf_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// File: verif/key_stuffed_stream_deframer_unit_test.sv
module key_stuffed_stream_deframer_unit_test;

    import ksdf_pkg::*;

    localparam int KEY_LEN = 12;
    // Terminator key, first byte in the top bits.
    localparam logic [8*KEY_LEN-1:0] END_KEY = {8'h66, 8'h74, 8'h5F, 8'h53, 8'h74, 8'h55,
                                                8'h66, 8'h46, 8'h5F, 8'h6B, 8'h65, 8'h79};
    localparam int HOLD_CYCLES = 220;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0] value;
        logic       ends;
    } link_item_t;

    typedef struct {
        logic [7:0]             data_byte;
        logic                   is_marker;
        logic                   truncated;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic                   last;
    } deframe_result_t;

    // Receiver behaviors between long hold-offs.
    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_t;

    // Kinds of random stimulus sequences.
    typedef enum int {
        SEQ_FRAME, SEQ_NOISE, SEQ_PREFIX, SEQ_STUFFED, SEQ_END, SEQ_BROKEN
    } seq_kind_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [7:0] cfg_wr_data;

    ksdf_in_if  in_ch();
    ksdf_out_if out_ch();

    key_stuffed_stream_deframer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Byte of the terminator key at a given position.
    function automatic logic [7:0] key_at(int unsigned pos);
        return END_KEY[8*(KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic string show(deframe_result_t r);
        return $sformatf("data=%02h marker=%0b trunc=%0b len=%0d last=%0b",
                         r.data_byte, r.is_marker, r.truncated, r.frame_length, r.last);
    endfunction

    // Tracks the key match and frame length, and holds the results still owed.
    class deframe_scoreboard;
        logic [7:0]             stuff;
        int unsigned            key_pos;
        logic [FRAME_LEN_W-1:0] frame_bytes;
        deframe_result_t        owed[$];
        int unsigned            errors;
        int unsigned            accepted;
        int unsigned            results;
        int unsigned            markers;
        int unsigned            truncs;
        int unsigned            stuff_drops;

        function new();
            stuff = STUFF_RESET;
            key_pos = 0;
            frame_bytes = '0;
            errors = 0;
            accepted = 0;
            results = 0;
            markers = 0;
            truncs = 0;
            stuff_drops = 0;
        endfunction

        function void set_stuff(logic [7:0] value);
            stuff = value;
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t mismatch %0d: %s", $time, errors, what);
        endfunction

        // A recovered payload byte; the frame length saturates.
        function void push_data(logic [7:0] b);
            deframe_result_t r;
            r.data_byte = b;
            r.is_marker = 1'b0;
            r.truncated = 1'b0;
            r.frame_length = '0;
            r.last = 1'b0;
            owed.push_back(r);
            if (frame_bytes != '1)
                frame_bytes++;
        endfunction

        function void push_marker(logic trunc);
            deframe_result_t r;
            r.data_byte = 8'h00;
            r.is_marker = 1'b1;
            r.truncated = trunc;
            r.frame_length = frame_bytes;
            r.last = 1'b0;
            owed.push_back(r);
            markers++;
            if (trunc)
                truncs++;
            key_pos = 0;
            frame_bytes = '0;
        endfunction

        // Held key bytes go out as data.
        function void release_prefix();
            for (int unsigned i = 0; i < key_pos; i++)
                push_data(key_at(i));
            key_pos = 0;
        endfunction

        function void note_input(logic [7:0] b, logic ends);
            int unsigned first;
            first = owed.size();
            accepted++;
            if (ends)
            begin
                push_marker(1'b1);
            end
            else if (key_pos < KEY_LEN && key_at(key_pos) == b)
            begin
                key_pos++;
                if (key_pos == KEY_LEN)
                    push_marker(1'b0);
            end
            else if (b == stuff && key_pos == KEY_LEN - 1)
            begin
                release_prefix();
                stuff_drops++;
            end
            else
            begin
                release_prefix();
                push_data(b);
            end
            if (owed.size() > first)
                owed[owed.size()-1].last = 1'b1;
        endfunction

        function void check_result(deframe_result_t got);
            deframe_result_t want;
            results++;
            if (owed.size() == 0)
            begin
                flag($sformatf("unexpected result %s", show(got)));
                return;
            end
            want = owed.pop_front();
            if (got.data_byte !== want.data_byte || got.is_marker !== want.is_marker ||
                got.truncated !== want.truncated || got.frame_length !== want.frame_length ||
                got.last !== want.last)
                flag($sformatf("expected %s got %s", show(want), show(got)));
        endfunction

        function void check_leftovers();
            while (owed.size() != 0)
                flag($sformatf("missing result %s", show(owed.pop_front())));
        endfunction
    endclass

    deframe_scoreboard sb;
    link_item_t stim_q[$];
    int unsigned holds_requested;
    int unsigned holds_started;
    int unsigned settings_used;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("key_stuffed_stream_deframer_unit_test: errors");
        $finish;
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        deframe_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.data_byte = out_ch.data_byte;
            got.is_marker = out_ch.is_marker;
            got.truncated = out_ch.truncated;
            got.frame_length = out_ch.frame_length;
            got.last = out_ch.last;
            sb.check_result(got);
        end
    end

    // Receiver: changing stall patterns, with long hold-offs on request.
    initial
    begin
        rx_mode_t mode;
        int mode_left;
        int period;
        int tick;
        int hold_left;
        mode = RX_OPEN;
        mode_left = 0;
        period = 2;
        tick = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_started < holds_requested)
            begin
                holds_started++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                    period = $urandom_range(2, 5);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_OPEN:     out_ch.ready <= 1'b1;
                    RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: out_ch.ready <= (tick % period == 0);
                    default:     out_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic void add_byte(logic [7:0] b);
        link_item_t it;
        it.value = b;
        it.ends = 1'b0;
        stim_q.push_back(it);
    endfunction

    // The byte field carries random content on a stream end.
    function automatic void add_end();
        link_item_t it;
        it.value = 8'($urandom_range(0, 255));
        it.ends = 1'b1;
        stim_q.push_back(it);
    endfunction

    function automatic void add_prefix(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            add_byte(key_at(i));
    endfunction

    // Mostly uniform bytes, with key bytes and the stuff byte mixed in.
    function automatic logic [7:0] any_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 8'($urandom_range(0, 255));
        else if (pick < 9)
            return key_at($urandom_range(0, KEY_LEN - 1));
        else
            return sb.stuff;
    endfunction

    // A sender-side frame: payload with stuffed near-keys, closed by the key.
    function automatic void add_frame();
        int unsigned len;
        len = $urandom_range(0, 14);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                add_prefix(KEY_LEN - 1);
                add_byte(sb.stuff);
            end
            else
            begin
                add_byte(any_byte());
            end
        end
        add_prefix(KEY_LEN);
    endfunction

    function automatic void build_random(int unsigned count);
        int unsigned target;
        int unsigned pick;
        seq_kind_t kind;
        target = stim_q.size() + count;
        while (stim_q.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = SEQ_FRAME;
            else if (pick < 58) kind = SEQ_NOISE;
            else if (pick < 74) kind = SEQ_PREFIX;
            else if (pick < 84) kind = SEQ_STUFFED;
            else if (pick < 91) kind = SEQ_END;
            else                kind = SEQ_BROKEN;
            case (kind)
                SEQ_FRAME:  add_frame();
                SEQ_NOISE:  add_byte(8'($urandom_range(0, 255)));
                SEQ_PREFIX:
                begin
                    add_prefix($urandom_range(1, KEY_LEN - 1));
                    add_byte(any_byte());
                end
                SEQ_STUFFED:
                begin
                    add_prefix(KEY_LEN - 1);
                    add_byte(sb.stuff);
                end
                SEQ_END:    add_end();
                default:
                begin
                    add_prefix($urandom_range(1, KEY_LEN - 1));
                    add_end();
                end
            endcase
        end
    endfunction

    // Offer queued items in bursts of random length with random gaps.
    task automatic send_items();
        link_item_t it;
        int burst_left;
        int gap;
        burst_left = 0;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            @(negedge clk);
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                          : $urandom_range(1, 20);
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            in_ch.valid <= 1'b1;
            in_ch.in_byte <= it.value;
            in_ch.stream_end <= it.ends;
            do @(posedge clk); while (!in_ch.ready);
            sb.note_input(it.value, it.ends);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every owed result is in, then let the pipeline settle.
    task automatic drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_stuff(logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_stuff(value);
        settings_used++;
    endtask

    // Main sequence.
    initial
    begin
        logic [7:0] settings[4];
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 8'h00;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.stream_end <= 1'b0;
        holds_requested = 0;
        holds_started = 0;
        settings_used = 1;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed cases with the stuff byte at its reset value.
        add_byte(8'h00);
        add_prefix(KEY_LEN);
        add_end();
        add_prefix(KEY_LEN - 1);
        add_byte(sb.stuff);
        add_prefix(3);
        add_byte(key_at(0));
        add_byte(sb.stuff);
        add_prefix(2);
        add_end();
        add_byte(8'hFF);
        send_items();
        drain();

        // Random phases, each under its own stuff byte.
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = key_at(0);
        settings[3] = 8'($urandom_range(0, 255));
        build_random(70);
        holds_requested++;
        send_items();
        drain();
        for (int s = 0; s < 4; s++)
        begin
            write_stuff(settings[s]);
            build_random(75);
            if (s == 2)
                holds_requested++;
            send_items();
            drain();
        end

        sb.check_leftovers();
        $display("%0d items in, %0d results out over %0d stuff settings",
                 sb.accepted, sb.results, settings_used);
        $display("%0d frame ends (%0d cut short), %0d stuff bytes dropped",
                 sb.markers, sb.truncs, sb.stuff_drops);
        if (sb.errors == 0)
            $display("key_stuffed_stream_deframer_unit_test: clean");
        else
            $display("key_stuffed_stream_deframer_unit_test: errors");
        $finish;
    end

endmodule
